@@ design/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the i2c master byte engine
// Command codes, queue words and phase constants used by all modules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // raw action codes on the input port
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // classified command, also the engine's active command
  typedef enum logic [4:0] {
    CMD_IDLE  = 5'b00001,
    CMD_START = 5'b00010,
    CMD_STOP  = 5'b00100,
    CMD_WRITE = 5'b01000,
    CMD_READ  = 5'b10000
  } cmd_t;

  // phase steps within a bit or a start/stop sequence
  localparam logic [1:0] STEP_LOW  = 2'd0;
  localparam logic [1:0] STEP_HIGH = 2'd1;
  localparam logic [1:0] STEP_END  = 2'd2;

  // bit positions
  localparam logic [3:0] ACK_BIT  = 4'd8;
  localparam logic [3:0] LAST_BIT = 4'd7;

  // phase_ticks register
  localparam int PHASE_TICKS_W = 16;
  localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 16'd1;

  // two-entry queues on both sides
  localparam logic [1:0] QUEUE_FULL = 2'd2;

  // word from the front to the engine
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // word from the engine to the result queue
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_level;
    logic       rejected;
  } result_t;

endpackage

@@ design/i2c_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: tick-stepped i2c bus master
// Top level: input queue with command decode, phase sequencer, result queue.
// ----------------------------------------------------------------------------
// Each input word is one bus tick: an action (tick, start, stop, write byte,
// read byte) plus the sampled SDA level, and each produces exactly one result
// word with the SCL/SDA drive levels after that tick and the status flags.
// The engine takes one word per clock while the result queue has room; a
// word passes through a two-entry input queue and the sequencer into a
// two-entry result queue, its result being registered into that queue when
// the word is accepted, and either side may stall without stopping the
// other until its queue fills.
// phase_ticks is written over the cfg channel, which is always ready.
module i2c_master_byte_engine #(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action,
  input  logic [7:0]  tx_byte,
  input  logic        send_ack,
  input  logic        sda_in,
  output logic        empty,
  input  logic        pop,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        ack_level,
  output logic        rejected
);

  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t head;
  logic              item_valid;
  logic              item_take;
  logic              res_valid;
  logic              res_ready;

  assign cfg_ready = 1'b1;

  // front: decode and queue input words
  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .tx_byte    (tx_byte),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // back: phase sequencer
  i2cm_engine #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result queue
  i2cm_res_queue u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  // result ports
  assign scl_out   = head.scl;
  assign sda_out   = head.sda;
  assign busy_res  = head.busy;
  assign done_res  = head.done;
  assign rx_byte   = head.rx_byte;
  assign ack_level = head.ack_level;
  assign rejected  = head.rejected;

endmodule

@@ design/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// i2cm_front: input side of the i2c master byte engine
// Accepts input words, decodes the action into a command and holds them in
// a two-entry queue until the engine takes them.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           action,
  input  logic [7:0]           tx_byte,
  input  logic                 send_ack,
  input  logic                 sda_in,
  output logic                 item_valid,
  output i2cm_pkg::item_t      item,
  input  logic                 item_take
);

  i2cm_pkg::item_t mem [2];
  i2cm_pkg::item_t new_item;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  // action decode, unknown codes act as tick only
  always_comb begin
    new_item.tx_byte  = tx_byte;
    new_item.send_ack = send_ack;
    new_item.sda_in   = sda_in;
    case (action)
      i2cm_pkg::ACT_START: new_item.cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::ACT_STOP:  new_item.cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::ACT_WRITE: new_item.cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::ACT_READ:  new_item.cmd = i2cm_pkg::CMD_READ;
      default:             new_item.cmd = i2cm_pkg::CMD_IDLE;
    endcase
  end

  assign full       = (count == i2cm_pkg::QUEUE_FULL);
  assign item_valid = (count != 2'd0);
  assign item       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_valid && item_take;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= new_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule

@@ design/i2cm_engine.sv @@
// ----------------------------------------------------------------------------
// i2cm_engine: bus phase sequencer of the i2c master byte engine
// Takes one word per cycle while res_ready holds, advances the phase counter
// and SCL/SDA levels, shifts data bits, gives one result word per input word.
// ----------------------------------------------------------------------------
module i2cm_engine #(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [i2cm_pkg::PHASE_TICKS_W-1:0]    cfg_data,
  input  logic                                  item_valid,
  input  i2cm_pkg::item_t                       item,
  output logic                                  item_take,
  input  logic                                  res_ready,
  output logic                                  res_valid,
  output i2cm_pkg::result_t                     res
);

  localparam int W  = TICK_COUNTER_WIDTH;
  localparam int LW = (W > i2cm_pkg::PHASE_TICKS_W) ? W : i2cm_pkg::PHASE_TICKS_W;

  logic [i2cm_pkg::PHASE_TICKS_W-1:0] phase_ticks;
  logic                               scl_level,  scl_level_next;
  logic                               sda_level,  sda_level_next;
  logic [7:0]                         shift_reg,  shift_reg_next;
  logic [3:0]                         bit_index,  bit_index_next;
  logic [1:0]                         phase_step, phase_step_next;
  logic [W-1:0]                       tick_count, tick_count_next;
  i2cm_pkg::cmd_t                     active_command, active_command_next;
  logic                               ack_choice, ack_choice_next;
  logic                               ack_seen,   ack_seen_next;
  logic [7:0]                         received_byte, received_byte_next;

  logic [W-1:0]  tick_inc;
  logic [LW-1:0] pt_w;
  logic [LW-1:0] mask_w;
  logic [LW-1:0] limit;
  logic          rejected;
  logic          done;
  logic          finish;
  logic          do_load;
  logic [1:0]    lev;

  // scl/sda levels of a phase, returned as {scl, sda}
  function automatic logic [1:0] phase_levels(i2cm_pkg::cmd_t cmd, logic [1:0] st,
                                              logic [3:0] bi, logic msb, logic ackc,
                                              logic sda_old);
    logic scl_v;
    logic sda_v;
    scl_v = 1'b0;
    sda_v = sda_old;
    if (cmd == i2cm_pkg::CMD_START) begin
      scl_v = (st != i2cm_pkg::STEP_END);
      sda_v = (st == i2cm_pkg::STEP_LOW);
    end else if (cmd == i2cm_pkg::CMD_STOP) begin
      scl_v = (st != i2cm_pkg::STEP_LOW);
      sda_v = (st == i2cm_pkg::STEP_END);
    end else if (st == i2cm_pkg::STEP_LOW) begin
      scl_v = 1'b0;
      if (bi >= i2cm_pkg::ACK_BIT) begin
        sda_v = (cmd == i2cm_pkg::CMD_READ) ? ~ackc : 1'b1;
      end else if (cmd == i2cm_pkg::CMD_WRITE) begin
        sda_v = msb;
      end else begin
        sda_v = 1'b1;
      end
    end else if (st == i2cm_pkg::STEP_HIGH) begin
      scl_v = 1'b1;
    end else begin
      scl_v = 1'b0;
      sda_v = 1'b1;
    end
    return {scl_v, sda_v};
  endfunction

  assign item_take = item_valid && res_ready;
  assign res_valid = item_take;

  // phase length, zero as one, saturated to the counter range
  always_comb begin
    pt_w   = LW'(phase_ticks);
    mask_w = LW'({W{1'b1}});
    if (pt_w == '0) limit = LW'(1);
    else if (pt_w > mask_w) limit = mask_w;
    else limit = pt_w;
  end

  assign tick_inc = tick_count + W'(1);

  // next state for one tick
  always_comb begin
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    shift_reg_next      = shift_reg;
    bit_index_next      = bit_index;
    phase_step_next     = phase_step;
    tick_count_next     = tick_count;
    active_command_next = active_command;
    ack_choice_next     = ack_choice;
    ack_seen_next       = ack_seen;
    received_byte_next  = received_byte;
    rejected            = 1'b0;
    done                = 1'b0;
    finish              = 1'b0;
    do_load             = 1'b0;
    if (active_command != i2cm_pkg::CMD_IDLE) begin
      rejected        = (item.cmd != i2cm_pkg::CMD_IDLE);
      tick_count_next = tick_inc;
      if (LW'(tick_inc) >= limit) begin
        tick_count_next = '0;
        if (active_command == i2cm_pkg::CMD_START ||
            active_command == i2cm_pkg::CMD_STOP) begin
          if (phase_step >= i2cm_pkg::STEP_END) begin
            finish = 1'b1;
          end else begin
            phase_step_next = phase_step + 2'd1;
            do_load         = 1'b1;
          end
        end else begin
          case (phase_step)
            i2cm_pkg::STEP_LOW: begin
              phase_step_next = i2cm_pkg::STEP_HIGH;
              do_load         = 1'b1;
            end
            i2cm_pkg::STEP_HIGH: begin
              if (bit_index < i2cm_pkg::ACK_BIT) begin
                if (active_command == i2cm_pkg::CMD_READ) begin
                  shift_reg_next = {shift_reg[6:0], item.sda_in};
                  if (bit_index == i2cm_pkg::LAST_BIT) begin
                    received_byte_next = {shift_reg[6:0], item.sda_in};
                  end
                end else begin
                  shift_reg_next = {shift_reg[6:0], 1'b0};
                end
                bit_index_next  = bit_index + 4'd1;
                phase_step_next = i2cm_pkg::STEP_LOW;
              end else begin
                if (active_command == i2cm_pkg::CMD_WRITE) ack_seen_next = item.sda_in;
                phase_step_next = i2cm_pkg::STEP_END;
              end
              do_load = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
        if (finish) begin
          active_command_next = i2cm_pkg::CMD_IDLE;
          phase_step_next     = i2cm_pkg::STEP_LOW;
          bit_index_next      = 4'd0;
          done                = 1'b1;
        end
      end
    end else if (item.cmd != i2cm_pkg::CMD_IDLE) begin
      active_command_next = item.cmd;
      phase_step_next     = i2cm_pkg::STEP_LOW;
      bit_index_next      = 4'd0;
      tick_count_next     = '0;
      if (item.cmd == i2cm_pkg::CMD_WRITE) shift_reg_next = item.tx_byte;
      if (item.cmd == i2cm_pkg::CMD_READ) begin
        shift_reg_next  = 8'd0;
        ack_choice_next = item.send_ack;
      end
      do_load = 1'b1;
    end
    lev = phase_levels(active_command_next, phase_step_next, bit_index_next,
                       shift_reg_next[7], ack_choice_next, sda_level);
    if (do_load) begin
      scl_level_next = lev[1];
      sda_level_next = lev[0];
    end
  end

  // result word, levels after this tick
  always_comb begin
    res.scl       = scl_level_next;
    res.sda       = sda_level_next;
    res.busy      = (active_command_next != i2cm_pkg::CMD_IDLE);
    res.done      = done;
    res.rx_byte   = received_byte_next;
    res.ack_level = ack_seen_next;
    res.rejected  = rejected;
  end

  // phase_ticks register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
    end else if (cfg_valid) begin
      phase_ticks <= cfg_data;
    end
  end

  // engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      shift_reg      <= 8'd0;
      bit_index      <= 4'd0;
      phase_step     <= i2cm_pkg::STEP_LOW;
      tick_count     <= '0;
      active_command <= i2cm_pkg::CMD_IDLE;
      ack_choice     <= 1'b0;
      ack_seen       <= 1'b1;
      received_byte  <= 8'd0;
    end else if (item_take) begin
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
      shift_reg      <= shift_reg_next;
      bit_index      <= bit_index_next;
      phase_step     <= phase_step_next;
      tick_count     <= tick_count_next;
      active_command <= active_command_next;
      ack_choice     <= ack_choice_next;
      ack_seen       <= ack_seen_next;
      received_byte  <= received_byte_next;
    end
  end

endmodule

@@ design/i2cm_res_queue.sv @@
// ----------------------------------------------------------------------------
// i2cm_res_queue: result side of the i2c master byte engine
// Two-entry queue of result words, read out through empty and pop.
// ----------------------------------------------------------------------------
module i2cm_res_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  i2cm_pkg::result_t res,
  output logic              res_ready,
  output logic              empty,
  input  logic              pop,
  output i2cm_pkg::result_t head
);

  i2cm_pkg::result_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_push;
  logic              do_pop;

  assign res_ready = (count != i2cm_pkg::QUEUE_FULL);
  assign empty     = (count == 2'd0);
  assign head      = mem[rd_ptr];
  assign do_push   = res_valid && res_ready;
  assign do_pop    = pop && !empty;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= res;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule
